/* sv/mcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared types and constants for the multi-channel PWM slot table.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

  localparam int CHANNELS    = 8;
  localparam int FRAME_TICKS = 1000 / 50 * 1000;   // one frame in microsecond ticks

  localparam int VAL_W  = 15;                      // period, compare and counter width
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_PAD = (CHANNELS > 8) ? CHANNELS : 8;
  localparam int CNT_W  = $clog2(VAL_W);

  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;
  localparam int M_PAD_W  = M_DATA_W - 20;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CHANGE = 2'd3
  } op_t;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

endpackage

/* sv/mcpwm_div.sv */
// ----------------------------------------------------------------------------
// mcpwm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcpwm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mcpwm_pkg::VAL_W-1:0] dividend,
  input  logic [mcpwm_pkg::VAL_W-1:0] divisor,
  output logic                       done,
  output logic [mcpwm_pkg::VAL_W-1:0] quo
);
  import mcpwm_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] rem;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[VAL_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        cnt  <= CNT_W'(VAL_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[VAL_W-1:0];
        end else begin
          rem <= trial[VAL_W-1:0];
        end
        quo <= {quo[VAL_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

/* sv/multi_channel_pwm_generator_unit.sv */
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator_unit
// Slot table of PWM channels sharing one frame; ticks, add, remove, change.
// ----------------------------------------------------------------------------
// Sequence: a tick item visits the table entries in S_TICK, one per cycle,
//   an add item waits in S_DIV for the step length from the bit-serial divider,
//   and remove and compare change go straight to S_DONE, which raises m_tvalid.
// Throughput: one item at a time; s_tready high only while idle, so a new item
//   is taken only after the last result is issued; a result may wait at the output.
// Reset: rst clears the sequencer, output valid and the enabled and off flags.
// ----------------------------------------------------------------------------
module multi_channel_pwm_generator_unit (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mcpwm_pkg::S_DATA_W-1:0] s_tdata,  // slot[2:0], period_steps[17:3],
                                                   // compare_value[32:18], zeros
  input  logic [mcpwm_pkg::S_USER_W-1:0] s_tuser,  // op[1:0]
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mcpwm_pkg::M_DATA_W-1:0] m_tdata   // levels[7:0], event_mask[15:8],
                                                   // given_slot[18:16], status[19], zeros
);
  import mcpwm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_DIV, S_DONE} state_t;

  // one slot's stored parameters and phase counters
  typedef struct packed {
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] compare;
    logic [VAL_W-1:0] step_length;
    logic [VAL_W-1:0] prescale;
    logic [VAL_W-1:0] step_index;
  } chan_t;

  state_t              state;
  logic [CH_W-1:0]     ch;          // sequencer slot pointer
  logic [CH_W-1:0]     found;       // slot taken by an add
  logic [VAL_W-1:0]    per_r;
  logic [VAL_W-1:0]    cmp_r;
  logic [CHANNELS-1:0] events;
  logic [CHANNELS-1:0] enabled;
  logic [CHANNELS-1:0] off_flag;
  logic [2:0]          given_r;
  logic                status_r;
  logic                div_start;
  chan_t               tbl [CHANNELS];

  // input item fields
  op_t              in_op;
  logic [2:0]       in_slot;
  logic [VAL_W-1:0] in_per;
  logic [VAL_W-1:0] in_cmp;
  logic [CH_W-1:0]  slot_idx;
  logic             slot_ok;

  assign in_op    = op_t'(s_tuser[1:0]);
  assign in_slot  = s_tdata[2:0];
  assign in_per   = s_tdata[17:3];
  assign in_cmp   = s_tdata[32:18];
  assign slot_idx = CH_W'(in_slot);
  assign slot_ok  = int'(in_slot) < CHANNELS;

  assign s_tready = (state == S_IDLE);

  // lowest free slot for an add
  logic            have_free;
  logic [CH_W-1:0] free_slot;

  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!enabled[i]) begin
        have_free = 1'b1;
        free_slot = CH_W'(i);
      end
    end
  end

  // per-slot tick update on the entry under the pointer
  chan_t            cur;
  logic             off_now;
  logic [VAL_W-1:0] ps_inc;
  logic [VAL_W-1:0] idx_inc;
  logic             ps_wrap;
  logic             idx_wrap;

  always_comb begin
    cur      = tbl[ch];
    off_now  = cur.step_index >= cur.compare;
    ps_inc   = cur.prescale + 1'b1;
    idx_inc  = cur.step_index + 1'b1;
    ps_wrap  = ps_inc >= cur.step_length;
    idx_wrap = idx_inc >= cur.period;
  end

  // step length = frame / period, through the shared divider
  logic             div_done;
  logic [VAL_W-1:0] div_quo;
  logic [VAL_W-1:0] step_len;

  mcpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (VAL_W'(FRAME_TICKS)),
    .divisor  (per_r),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign step_len = (div_quo == '0) ? VAL_W'(1) : div_quo;

  // result vectors, padded so that the low eight bits always exist
  logic [CH_PAD-1:0] levels_pad;
  logic [CH_PAD-1:0] events_pad;

  assign levels_pad = CH_PAD'(enabled & ~off_flag);
  assign events_pad = CH_PAD'(events);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      m_tvalid  <= 1'b0;
      enabled   <= '0;
      off_flag  <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            given_r  <= '0;
            status_r <= ST_OK;
            events   <= '0;
            ch       <= '0;
            case (in_op)
              OP_TICK: begin
                state <= S_TICK;
              end
              OP_ADD: begin
                if (have_free) begin
                  found     <= free_slot;
                  per_r     <= (in_per == '0) ? VAL_W'(1) : in_per;
                  cmp_r     <= in_cmp;
                  div_start <= 1'b1;
                  state     <= S_DIV;
                end else begin
                  status_r <= ST_NO_FREE;
                  state    <= S_DONE;
                end
              end
              OP_REMOVE: begin
                if (slot_ok) begin
                  enabled[slot_idx] <= 1'b0;
                end
                state <= S_DONE;
              end
              OP_CHANGE: begin
                // new compare restarts the phase at step 0
                if (slot_ok) begin
                  tbl[slot_idx].compare    <= in_cmp;
                  tbl[slot_idx].prescale   <= '0;
                  tbl[slot_idx].step_index <= '0;
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_TICK: begin
          if (enabled[ch]) begin
            // reissue the level when it flips or a new period starts
            if ((off_now != off_flag[ch]) || (cur.step_index == '0)) begin
              off_flag[ch] <= off_now;
              events[ch]   <= 1'b1;
            end
            tbl[ch].prescale <= ps_wrap ? '0 : ps_inc;
            if (ps_wrap) begin
              tbl[ch].step_index <= idx_wrap ? '0 : idx_inc;
            end
          end
          if (ch == CH_W'(CHANNELS - 1)) begin
            state <= S_DONE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            tbl[found].period      <= per_r;
            tbl[found].compare     <= cmp_r;
            tbl[found].step_length <= step_len;
            tbl[found].prescale    <= '0;
            tbl[found].step_index  <= '0;
            off_flag[found]        <= 1'b1;   // shows off until its first tick
            enabled[found]         <= 1'b1;
            given_r                <= 3'(found);
            state                  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {M_PAD_W'(0), status_r, given_r, events_pad[7:0], levels_pad[7:0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/mcpwm_chk.sv */
// ----------------------------------------------------------------------------
// mcpwm_chk
// Port-level checks for the PWM slot table, bound to the top level.
// ----------------------------------------------------------------------------
module mcpwm_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mcpwm_pkg::M_DATA_W-1:0] m_tdata
);
  import mcpwm_pkg::*;

  // a failed add gives no slot and no events
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[19] == ST_NO_FREE) |-> (m_tdata[18:16] == 3'd0 && m_tdata[15:8] == 8'd0))
    else $error("failed add carries slot or events");

  // one item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while busy");

  // no result straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind multi_channel_pwm_generator_unit mcpwm_chk u_chk (.*);
